[design/dsf_pkg.sv]
package dsf_pkg;

    localparam int LINE_LIMIT_DEF = 63;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [7:0]  BEGIN_RST   = 8'd36;
    localparam logic [7:0]  END_RST     = 8'd10;
    localparam logic [7:0]  IGN_A_RST   = 8'd13;
    localparam logic [7:0]  IGN_B_RST   = 8'd13;
    localparam logic [1:0]  IGN_CNT_RST = 2'd1;
    localparam logic        MODE_RST    = 1'b0;
    localparam logic [15:0] TIMEOUT_RST = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BEGIN   = 3'd0,
        REG_END     = 3'd1,
        REG_IGN_A   = 3'd2,
        REG_IGN_B   = 3'd3,
        REG_IGN_CNT = 3'd4,
        REG_MODE    = 3'd5,
        REG_TIMEOUT = 3'd6
    } dsf_reg_t;

    typedef enum logic [2:0] {
        S_ACCEPT,
        S_READ,
        S_SEND,
        S_TOUT,
        S_HALT
    } dsf_state_t;

    typedef struct packed {
        logic step;
        logic rd;
        logic adv;
        logic tout_sel;
    } dsf_cmd_t;

    typedef struct packed {
        logic emit;
        logic tout;
        logic last;
    } dsf_stat_t;

endpackage

[design/dsf_if.sv]
interface dsf_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface dsf_out_if;
    logic       valid;
    logic       ready;
    logic       out_kind;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_kind, output out_char, output last_char,
                    input ready);
    modport sink (input valid, input out_kind, input out_char, input last_char,
                  output ready);
endinterface

[design/dsf_ctrl.sv]
module dsf_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  dsf_pkg::dsf_stat_t stat,
    output dsf_pkg::dsf_cmd_t  cmd
);

    dsf_pkg::dsf_state_t state_reg;
    dsf_pkg::dsf_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsf_pkg::S_ACCEPT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            dsf_pkg::S_ACCEPT:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.step = 1'b1;
                    if (stat.tout)
                    begin
                        state_next = dsf_pkg::S_TOUT;
                    end
                    else if (stat.emit)
                    begin
                        state_next = dsf_pkg::S_READ;
                    end
                end
            end
            dsf_pkg::S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = dsf_pkg::S_SEND;
            end
            dsf_pkg::S_SEND:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.adv    = 1'b1;
                    state_next = stat.last ? dsf_pkg::S_ACCEPT : dsf_pkg::S_READ;
                end
            end
            dsf_pkg::S_TOUT:
            begin
                out_valid    = 1'b1;
                cmd.tout_sel = 1'b1;
                if (out_ready)
                begin
                    state_next = dsf_pkg::S_HALT;
                end
            end
            dsf_pkg::S_HALT:
            begin
                // link is dead: items are taken and dropped until reset
                in_ready = 1'b1;
            end
            default:
            begin
                state_next = dsf_pkg::S_ACCEPT;
            end
        endcase
    end

endmodule

[design/dsf_datapath.sv]
module dsf_datapath
#(
    parameter int LINE_LIMIT = dsf_pkg::LINE_LIMIT_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [dsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsf_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          req_type,
    input  logic [7:0]                    rx_byte,
    input  dsf_pkg::dsf_cmd_t             cmd,
    output dsf_pkg::dsf_stat_t            stat,
    output logic                          out_kind,
    output logic [7:0]                    out_char,
    output logic                          last_char
);

    localparam int DEPTH = LINE_LIMIT + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = $clog2(DEPTH + 1);
    localparam logic [LW-1:0] LIMIT_L = LW'(LINE_LIMIT);

    logic [7:0]  begin_reg;
    logic [7:0]  end_reg;
    logic [7:0]  ign_a_reg;
    logic [7:0]  ign_b_reg;
    logic [1:0]  ign_cnt_reg;
    logic        mode_reg;
    logic [15:0] timeout_reg;

    logic [LW-1:0] len_reg;
    logic          open_reg;
    logic          drop_reg;
    logic [15:0]   idle_reg;
    logic [LW-1:0] n_reg;
    logic [LW-1:0] k_reg;
    logic [7:0]    rdata_reg;

    logic [7:0] store_mem [DEPTH];

    logic          is_begin;
    logic          is_end;
    logic          ignored;
    logic          open_a;
    logic [LW-1:0] len_a;
    logic [LW-1:0] len_next;
    logic          open_next;
    logic          drop_next;
    logic [LW-1:0] emit_n;
    logic          wr_en;
    logic [15:0]   idle_next;
    logic [LW-1:0] k_next;

    always_comb
    begin
        is_begin  = rx_byte == begin_reg;
        is_end    = rx_byte == end_reg;
        ignored   = (ign_cnt_reg != 2'd0) &&
                    ((rx_byte == ign_a_reg) || (ign_cnt_reg[1] && (rx_byte == ign_b_reg)));
        open_a    = open_reg | is_begin;
        len_a     = is_begin ? '0 : len_reg;
        len_next  = len_a;
        open_next = open_a;
        drop_next = drop_reg;
        emit_n    = '0;
        wr_en     = 1'b0;
        if (open_a)
        begin
            if (is_end)
            begin
                open_next = mode_reg;
                len_next  = '0;
                if (drop_reg)
                begin
                    drop_next = 1'b0;
                end
                else
                begin
                    emit_n = len_a;
                end
            end
            else if (!ignored)
            begin
                wr_en    = 1'b1;
                len_next = len_a + LW'(1);
            end
        end
        // overlong line goes out at once and closes
        if (len_next > LIMIT_L)
        begin
            emit_n    = len_next;
            len_next  = '0;
            open_next = 1'b0;
        end
        idle_next = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
        k_next    = k_reg + LW'(1);
        stat.emit = !req_type && (emit_n != '0);
        stat.tout = req_type && (idle_next >= timeout_reg);
        stat.last = k_next == n_reg;
        out_kind  = cmd.tout_sel;
        out_char  = cmd.tout_sel ? 8'd0 : rdata_reg;
        last_char = cmd.tout_sel | stat.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_reg   <= dsf_pkg::BEGIN_RST;
            end_reg     <= dsf_pkg::END_RST;
            ign_a_reg   <= dsf_pkg::IGN_A_RST;
            ign_b_reg   <= dsf_pkg::IGN_B_RST;
            ign_cnt_reg <= dsf_pkg::IGN_CNT_RST;
            mode_reg    <= dsf_pkg::MODE_RST;
            timeout_reg <= dsf_pkg::TIMEOUT_RST;
            len_reg     <= '0;
            open_reg    <= dsf_pkg::MODE_RST;
            drop_reg    <= dsf_pkg::MODE_RST;
            idle_reg    <= '0;
            n_reg       <= '0;
            k_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    dsf_pkg::REG_BEGIN:   begin_reg   <= cfg_wdata[7:0];
                    dsf_pkg::REG_END:     end_reg     <= cfg_wdata[7:0];
                    dsf_pkg::REG_IGN_A:   ign_a_reg   <= cfg_wdata[7:0];
                    dsf_pkg::REG_IGN_B:   ign_b_reg   <= cfg_wdata[7:0];
                    dsf_pkg::REG_IGN_CNT: ign_cnt_reg <= cfg_wdata[1:0];
                    dsf_pkg::REG_MODE:
                    begin
                        mode_reg <= cfg_wdata[0];
                        open_reg <= cfg_wdata[0];
                        drop_reg <= cfg_wdata[0];
                    end
                    dsf_pkg::REG_TIMEOUT: timeout_reg <= cfg_wdata[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.step)
            begin
                if (req_type)
                begin
                    idle_reg <= idle_next;
                end
                else
                begin
                    idle_reg <= '0;
                    len_reg  <= len_next;
                    open_reg <= open_next;
                    drop_reg <= drop_next;
                    n_reg    <= emit_n;
                    k_reg    <= '0;
                end
            end
            if (cmd.adv)
            begin
                k_reg <= k_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step && !req_type && wr_en)
        begin
            store_mem[len_a[AW-1:0]] <= rx_byte;
        end
        if (cmd.rd)
        begin
            rdata_reg <= store_mem[k_reg[AW-1:0]];
        end
    end

endmodule

[design/delimited_sentence_framer.sv]
// a byte or idle tick that gives no result is taken and leaves the block ready for the next item
// a sentence of n characters: after the closing byte, each character is first read from memory
// and then offered on the output, where it waits for ready; no input is taken meanwhile
// a timeout result shows in the cycle after the tick; once it is taken the block drops all input
// reset (async, active low) restores register defaults, empties the line and clears halt
module delimited_sentence_framer
#(
    parameter int LINE_LIMIT = dsf_pkg::LINE_LIMIT_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    dsf_in_if.sink                        in_ch,
    dsf_out_if.source                     out_ch,
    input  logic                          cfg_we,
    input  logic [dsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsf_pkg::CFG_W-1:0]     cfg_wdata
);

    dsf_pkg::dsf_cmd_t  cmd;
    dsf_pkg::dsf_stat_t stat;

    dsf_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dsf_datapath #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_type  (in_ch.req_type),
        .rx_byte   (in_ch.rx_byte),
        .cmd       (cmd),
        .stat      (stat),
        .out_kind  (out_ch.out_kind),
        .out_char  (out_ch.out_char),
        .last_char (out_ch.last_char)
    );

endmodule

[design/dsf_checker.sv]
module dsf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       out_kind,
    input logic [7:0] out_char,
    input logic       last_char
);

    // input is held off while a result is on offer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while a result is pending");

    // nothing follows the timeout transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && out_kind) |=> !out_valid)
        else $error("result after link timeout");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_kind) |-> (last_char && (out_char == 8'd0)))
        else $error("malformed timeout result");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_char) && $stable(last_char)))
        else $error("stalled result changed");

endmodule

bind delimited_sentence_framer dsf_checker u_dsf_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.out_kind),
    .out_char  (out_ch.out_char),
    .last_char (out_ch.last_char)
);

[test/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int LINE_DEPTH = dsf_pkg::LINE_LIMIT_DEF + 1;
    localparam int DRAIN      = 8;
    localparam int MAX_SHOWN  = 10;
    localparam int NO_CHECK   = -1;
    localparam int PHASE_ITEMS = 120;

    localparam logic REQ_BYTE     = 1'b0;
    localparam logic REQ_IDLE     = 1'b1;
    localparam logic KIND_CHAR    = 1'b0;
    localparam logic KIND_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic               req;
        logic [15:0]        data;
        dsf_pkg::dsf_reg_t  idx;
        int                 exp_n;
        logic               exp_kind;
        logic [7:0]         exp_char;
    } row_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic       last;
    } frame_char_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [dsf_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dsf_pkg::CFG_W-1:0]     cfg_wdata;

    dsf_in_if  in_ch();
    dsf_out_if out_ch();

    delimited_sentence_framer dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // framer state as the block should hold it
    logic [7:0]  reg_begin   = dsf_pkg::BEGIN_RST;
    logic [7:0]  reg_end     = dsf_pkg::END_RST;
    logic [7:0]  reg_ign_a   = dsf_pkg::IGN_A_RST;
    logic [7:0]  reg_ign_b   = dsf_pkg::IGN_B_RST;
    logic [1:0]  reg_ign_cnt = dsf_pkg::IGN_CNT_RST;
    logic        reg_mode    = dsf_pkg::MODE_RST;
    logic [15:0] reg_timeout = dsf_pkg::TIMEOUT_RST;

    logic [7:0]  line_mem [LINE_DEPTH];
    logic [6:0]  line_len     = '0;
    logic        line_open    = dsf_pkg::MODE_RST;
    logic        drop_pending = dsf_pkg::MODE_RST;
    logic [15:0] idle_cnt     = '0;
    logic        halted       = 1'b0;

    frame_char_t pending_chars [$];
    row_t        rows [$];

    int errors        = 0;
    int items_sent    = 0;
    int chars_checked = 0;
    int sentences     = 0;
    int timeouts_seen = 0;
    int reg_writes    = 0;
    int sender_idle_pct = 0;
    int stall_pct       = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("delimited_sentence_framer test failed");
        $finish;
    end

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= MAX_SHOWN)
        begin
            $display("%s", msg);
        end
    endtask

    function automatic bit is_dropped_char(input logic [7:0] b);
        if (reg_ign_cnt == 2'd0)
            return 1'b0;
        if (b == reg_ign_a)
            return 1'b1;
        return (reg_ign_cnt >= 2'd2) && (b == reg_ign_b);
    endfunction

    function automatic bit idle_ok();
        return (int'(idle_cnt) + 1) < int'(reg_timeout);
    endfunction

    task automatic emit_line(inout int made);
        int n;
        int k;
        n = (line_len > LINE_DEPTH) ? LINE_DEPTH : int'(line_len);
        for (k = 0; k < n; k++)
        begin
            pending_chars.push_back('{KIND_CHAR, line_mem[k], (k + 1 == n)});
        end
        made += n;
        line_len = '0;
    endtask

    task automatic frame_item(input logic req, input logic [7:0] b, output int made);
        made = 0;
        if (halted)
            return;
        if (req == REQ_IDLE)
        begin
            if (idle_cnt != 16'hFFFF)
                idle_cnt++;
            if (idle_cnt >= reg_timeout)
            begin
                pending_chars.push_back('{KIND_TIMEOUT, 8'h00, 1'b1});
                halted = 1'b1;
                made = 1;
            end
            return;
        end
        idle_cnt = '0;
        if (b == reg_begin)
        begin
            line_open = 1'b1;
            line_len = '0;
        end
        if (line_open)
        begin
            if (b == reg_end)
            begin
                if (drop_pending)
                begin
                    drop_pending = 1'b0;
                    line_len = '0;
                end
                else
                begin
                    emit_line(made);
                end
                line_open = reg_mode;
            end
            else if (!is_dropped_char(b) && line_len < LINE_DEPTH)
            begin
                line_mem[line_len[5:0]] = b;
                line_len++;
            end
        end
        // overlong line goes out at once and stays closed
        if (line_len > dsf_pkg::LINE_LIMIT_DEF)
        begin
            emit_line(made);
            line_open = 1'b0;
        end
    endtask

    task automatic apply_reg(input dsf_pkg::dsf_reg_t idx, input logic [15:0] val);
        case (idx)
            dsf_pkg::REG_BEGIN:   reg_begin = val[7:0];
            dsf_pkg::REG_END:     reg_end = val[7:0];
            dsf_pkg::REG_IGN_A:   reg_ign_a = val[7:0];
            dsf_pkg::REG_IGN_B:   reg_ign_b = val[7:0];
            dsf_pkg::REG_IGN_CNT: reg_ign_cnt = val[1:0];
            dsf_pkg::REG_MODE:
            begin
                reg_mode = val[0];
                line_open = val[0];
                drop_pending = val[0];
            end
            dsf_pkg::REG_TIMEOUT: reg_timeout = val;
            default: ;
        endcase
    endtask

    task automatic write_reg(input dsf_pkg::dsf_reg_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        apply_reg(idx, val);
        reg_writes++;
    endtask

    task automatic send_item(input logic req, input logic [7:0] b, output int made);
        while (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.req_type <= req;
        in_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        frame_item(req, b, made);
    endtask

    // no input pending and every result drained
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_chars.size() != 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic row_t item_row(input logic req, input logic [7:0] b, input int n,
                                      input logic kind, input logic [7:0] ch);
        return '{ROW_ITEM, req, {8'h00, b}, dsf_pkg::REG_BEGIN, n, kind, ch};
    endfunction

    function automatic row_t reg_row(input dsf_pkg::dsf_reg_t idx, input logic [15:0] val);
        return '{ROW_REG, REQ_BYTE, val, idx, NO_CHECK, KIND_CHAR, 8'h00};
    endfunction

    task automatic run_rows(input int first, input int last);
        int i;
        int made;
        int pos;
        for (i = first; i <= last; i++)
        begin
            if (rows[i].kind == ROW_REG)
            begin
                if (i == first || rows[i-1].kind != ROW_REG)
                    wait_quiet();
                write_reg(rows[i].idx, rows[i].data);
                if (i == last || rows[i+1].kind != ROW_REG)
                    cfg_we <= 1'b0;
            end
            else
            begin
                send_item(rows[i].req, rows[i].data[7:0], made);
                pos = pending_chars.size() - made;
                if (rows[i].exp_n != NO_CHECK &&
                    (made != rows[i].exp_n ||
                     (made > 0 && (pending_chars[pos].kind != rows[i].exp_kind ||
                                   pending_chars[pos].ch != rows[i].exp_char))))
                begin
                    flag_error($sformatf(
                        "row %0d: expected %0d results first kind=%0d char=%h, predicted %0d",
                        i, rows[i].exp_n, rows[i].exp_kind, rows[i].exp_char, made));
                end
            end
        end
    endtask

    task automatic program_phase(input int p);
        case (p)
            0:
            begin
                write_reg(dsf_pkg::REG_BEGIN, 16'h0000);
                write_reg(dsf_pkg::REG_END, 16'h00FF);
                write_reg(dsf_pkg::REG_IGN_A, 16'h0080);
                write_reg(dsf_pkg::REG_IGN_B, 16'h007F);
                write_reg(dsf_pkg::REG_IGN_CNT, 16'd2);
                write_reg(dsf_pkg::REG_MODE, 16'd0);
                write_reg(dsf_pkg::REG_TIMEOUT, 16'hFFFF);
            end
            1:
            begin
                write_reg(dsf_pkg::REG_BEGIN, 16'h00FF);
                write_reg(dsf_pkg::REG_END, 16'h0000);
                write_reg(dsf_pkg::REG_IGN_A, 16'($urandom_range(1, 254)));
                write_reg(dsf_pkg::REG_IGN_B, 16'($urandom_range(1, 254)));
                write_reg(dsf_pkg::REG_IGN_CNT, 16'd0);
                write_reg(dsf_pkg::REG_MODE, 16'd1);
                write_reg(dsf_pkg::REG_TIMEOUT, 16'd1);
            end
            2:
            begin
                write_reg(dsf_pkg::REG_BEGIN, {8'h00, dsf_pkg::BEGIN_RST});
                write_reg(dsf_pkg::REG_END, {8'h00, dsf_pkg::END_RST});
                write_reg(dsf_pkg::REG_IGN_A, {8'h00, dsf_pkg::IGN_A_RST});
                write_reg(dsf_pkg::REG_IGN_B, 16'($urandom_range(0, 255)));
                write_reg(dsf_pkg::REG_IGN_CNT, 16'd1);
                write_reg(dsf_pkg::REG_MODE, 16'd0);
                write_reg(dsf_pkg::REG_TIMEOUT, 16'($urandom_range(2, 40)));
            end
            default:
            begin
                write_reg(dsf_pkg::REG_BEGIN, 16'($urandom_range(0, 255)));
                write_reg(dsf_pkg::REG_END, 16'($urandom_range(0, 255)));
                write_reg(dsf_pkg::REG_IGN_A, 16'($urandom_range(0, 255)));
                write_reg(dsf_pkg::REG_IGN_B, 16'($urandom_range(0, 255)));
                write_reg(dsf_pkg::REG_IGN_CNT, 16'($urandom_range(0, 3)));
                write_reg(dsf_pkg::REG_MODE, 16'($urandom_range(0, 1)));
                write_reg(dsf_pkg::REG_TIMEOUT, 16'($urandom_range(1, 50)));
            end
        endcase
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int n_items);
        int sent;
        int len;
        int r;
        int k;
        int made;
        logic [7:0] b;
        sent = 0;
        while (sent < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                // mostly well-formed sentences, a few with the opener or closer missing
                if ((!reg_mode || $urandom_range(0, 3) == 0) && $urandom_range(0, 9) != 0)
                begin
                    send_item(REQ_BYTE, reg_begin, made);
                    sent++;
                end
                len = ($urandom_range(0, 11) == 0) ? $urandom_range(55, 70)
                                                   : $urandom_range(0, 12);
                for (k = 0; k < len; k++)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 8 && idle_ok())
                    begin
                        send_item(REQ_IDLE, 8'($urandom_range(0, 255)), made);
                    end
                    else
                    begin
                        if (r < 18)
                            b = $urandom_range(0, 1) ? reg_ign_a : reg_ign_b;
                        else
                        begin
                            b = 8'($urandom_range(0, 255));
                            if ((b == reg_begin || b == reg_end) && $urandom_range(0, 19) != 0)
                                b = b ^ 8'h01;
                        end
                        send_item(REQ_BYTE, b, made);
                    end
                    sent++;
                end
                if ($urandom_range(0, 19) != 0)
                begin
                    send_item(REQ_BYTE, reg_end, made);
                    sent++;
                end
            end
            else if (r < 92 || !idle_ok())
            begin
                send_item(REQ_BYTE, 8'($urandom_range(0, 255)), made);
                sent++;
            end
            else
            begin
                // idle burst that may run right up to one short of the timeout
                k = $urandom_range(1, 40);
                while (k > 0 && idle_ok())
                begin
                    send_item(REQ_IDLE, 8'($urandom_range(0, 255)), made);
                    k--;
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        frame_char_t head;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_chars.size() == 0)
            begin
                flag_error($sformatf("unexpected result kind=%0d char=%h last=%0d",
                                     out_ch.out_kind, out_ch.out_char, out_ch.last_char));
            end
            else
            begin
                head = pending_chars.pop_front();
                if (out_ch.out_kind !== head.kind || out_ch.out_char !== head.ch ||
                    out_ch.last_char !== head.last)
                begin
                    flag_error($sformatf(
                        "result mismatch: expected kind=%0d char=%h last=%0d, %s",
                        head.kind, head.ch, head.last,
                        $sformatf("got kind=%0d char=%h last=%0d",
                                  out_ch.out_kind, out_ch.out_char, out_ch.last_char)));
                end
                if (head.kind == KIND_TIMEOUT)
                    timeouts_seen++;
                else
                begin
                    chars_checked++;
                    if (head.last)
                        sentences++;
                end
            end
        end
    end

    initial
    begin
        int n_directed;
        int p;
        in_ch.valid = 1'b0;
        in_ch.req_type = REQ_BYTE;
        in_ch.rx_byte = 8'h00;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        rst_n = 1'b0;

        // register defaults: '$' opens, newline closes, carriage return dropped
        rows.push_back(item_row(REQ_IDLE, 8'hFF, 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, "A", 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, "$", 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, "G", 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, 8'h0D, 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, 8'h00, 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, 8'hFF, 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, 8'h0A, 4, KIND_CHAR, "$"));
        rows.push_back(item_row(REQ_BYTE, 8'h0A, 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, "$", 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, 8'h0A, 1, KIND_CHAR, "$"));
        // empty ignore set keeps carriage return
        rows.push_back(reg_row(dsf_pkg::REG_IGN_CNT, 16'd0));
        rows.push_back(item_row(REQ_BYTE, "$", 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, 8'h0D, 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, 8'h0A, 2, KIND_CHAR, "$"));
        // count of three acts as two
        rows.push_back(reg_row(dsf_pkg::REG_IGN_CNT, 16'd3));
        rows.push_back(reg_row(dsf_pkg::REG_IGN_B, 16'h0041));
        rows.push_back(item_row(REQ_BYTE, "$", NO_CHECK, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, "A", NO_CHECK, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, 8'h0D, NO_CHECK, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, "C", NO_CHECK, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, 8'h0A, 2, KIND_CHAR, "$"));
        // end-only mode: first sentence dropped, next one framed
        rows.push_back(reg_row(dsf_pkg::REG_MODE, 16'd1));
        rows.push_back(item_row(REQ_BYTE, "M", 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, 8'h0A, 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, "N", 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, 8'h0A, 1, KIND_CHAR, "N"));
        // opener equal to closer gives an empty sentence
        rows.push_back(reg_row(dsf_pkg::REG_MODE, 16'd0));
        rows.push_back(reg_row(dsf_pkg::REG_BEGIN, 16'h000A));
        rows.push_back(item_row(REQ_BYTE, "P", 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, 8'h0A, 0, KIND_CHAR, 8'h00));
        // byte extremes as delimiters
        rows.push_back(reg_row(dsf_pkg::REG_BEGIN, 16'h0000));
        rows.push_back(reg_row(dsf_pkg::REG_END, 16'h00FF));
        rows.push_back(item_row(REQ_BYTE, 8'h00, 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, 8'hFF, 1, KIND_CHAR, 8'h00));
        // a byte between idle ticks restarts the count
        rows.push_back(reg_row(dsf_pkg::REG_TIMEOUT, 16'd2));
        rows.push_back(reg_row(dsf_pkg::REG_IGN_A, 16'h00FF));
        rows.push_back(item_row(REQ_IDLE, 8'h00, 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_BYTE, "x", 0, KIND_CHAR, 8'h00));
        rows.push_back(item_row(REQ_IDLE, 8'hFF, 0, KIND_CHAR, 8'h00));
        n_directed = rows.size();
        // zero timeout trips on the first idle tick and halts the block
        rows.push_back(reg_row(dsf_pkg::REG_TIMEOUT, 16'd0));
        rows.push_back(item_row(REQ_IDLE, 8'h5A, 1, KIND_TIMEOUT, 8'h00));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        run_rows(0, n_directed - 1);

        for (p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 74;
                    stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct = 74;
                end
                default:
                begin
                    sender_idle_pct = 30;
                    stall_pct = 30;
                end
            endcase
            wait_quiet();
            program_phase(p);
            run_random(PHASE_ITEMS);
        end

        run_rows(n_directed, rows.size() - 1);
        wait_quiet();

        $display("sent %0d bytes and idle ticks under %0d register writes",
                 items_sent, reg_writes);
        $display("checked %0d characters in %0d sentences and %0d link timeout",
                 chars_checked, sentences, timeouts_seen);
        if (errors == 0)
            $display("delimited_sentence_framer test passed");
        else
            $display("delimited_sentence_framer test failed");
        $finish;
    end

endmodule
